[rtl/oht_pkg.sv]
package oht_pkg;

	localparam int KEY_W       = 31;
	localparam int STAT_W      = 8;
	localparam int REC_W       = 32;
	localparam int OCC_W       = 11;
	// home slot takes a reciprocal multiply and then a back-multiply
	localparam int HASH_STEPS  = 2;
	localparam int HSTEP_W     = $clog2(HASH_STEPS);

	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_REMOVE     = 2'd1,
		OP_LOOKUP     = 2'd2,
		OP_SET_STATUS = 2'd3
	} oht_op_t;

	typedef struct packed {
		oht_op_t             opcode;
		logic [KEY_W-1:0]    key;
		logic [STAT_W-1:0]   new_status;
		logic [REC_W-1:0]    record_ref;
	} oht_req_t;

	typedef struct packed {
		logic                ok;
		logic [STAT_W-1:0]   status_out;
		logic [REC_W-1:0]    record_out;
		logic [OCC_W-1:0]    occupancy;
	} oht_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_UPDATE,
		ST_DONE
	} oht_state_t;

	typedef struct packed {
		logic clear_en;
		logic accept;
		logic hash_en;
		logic probe;
		logic upd_en;
		logic load;
	} oht_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic hash_last;
		logic reject;
		logic hit;
		logic miss;
	} oht_stat_t;

endpackage

[rtl/oht_ctrl.sv]
module oht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  oht_pkg::oht_stat_t stat,
	output oht_pkg::oht_cmd_t  cmd
);
	import oht_pkg::*;

	oht_state_t state_q, state_next;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) state_next = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_next = ST_HASH;
			end
			ST_HASH: begin
				if (stat.hash_last) state_next = stat.reject ? ST_DONE : ST_PROBE;
			end
			ST_PROBE: begin
				if (stat.hit) state_next = ST_UPDATE;
				else if (stat.miss) state_next = ST_DONE;
			end
			ST_UPDATE: begin
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) state_next = ST_IDLE;
			end
			default: state_next = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR:  cmd.clear_en = 1'b1;
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_HASH:   cmd.hash_en = 1'b1;
			ST_PROBE:  cmd.probe = 1'b1;
			ST_UPDATE: cmd.upd_en = 1'b1;
			ST_DONE:   cmd.load = slot_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_update_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> $past(state_q) == ST_PROBE)
		else $error("update without a preceding probe hit");
	a_probe_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> ($past(state_q) == ST_HASH || $past(state_q) == ST_PROBE))
		else $error("probe entered from wrong state");
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("response raised outside done");
`endif
endmodule

[rtl/oht_dp.sv]
module oht_dp #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  oht_pkg::oht_req_t  req,
	input  oht_pkg::oht_cmd_t  cmd,
	output oht_pkg::oht_stat_t stat,
	output oht_pkg::oht_rsp_t  rsp
);
	import oht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam logic [IDX_W:0] T_EXT  = (IDX_W+1)'(TABLE_SIZE);
	localparam logic [IDX_W:0] T_LAST = (IDX_W+1)'(TABLE_SIZE - 1);
	// reciprocal of the table size rounded up, exact quotient for every 31-bit key
	localparam int             SHIFT  = KEY_W + IDX_W;
	localparam logic [KEY_W:0] RECIP  =
		(KEY_W+1)'(((64'd1 << SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));

	logic [KEY_W-1:0]  key_mem [TABLE_SIZE];
	logic [STAT_W-1:0] st_mem  [TABLE_SIZE];
	logic [REC_W-1:0]  rec_mem [TABLE_SIZE];

	// item registers
	oht_op_t           op_q;
	logic [KEY_W-1:0]  key_q;
	logic [STAT_W-1:0] nst_q;
	logic [REC_W-1:0]  rin_q;

	// clear sweep
	logic [IDX_W-1:0]  clr_q;

	// home slot: quotient by reciprocal, remainder by back-multiply
	logic [2*KEY_W:0]   h_prod;
	logic [KEY_W-1:0]   quot_q, h_back;
	logic [IDX_W-1:0]   rem_next;
	logic [HSTEP_W-1:0] hstep_q;

	// probe issue and check stage
	logic [IDX_W-1:0]  pos_q, pos_next;
	logic [IDX_W:0]    k_q, pos_sum;
	logic              issue;
	logic              valid_s1, last_s1;
	logic [IDX_W-1:0]  pos_s1;
	logic [KEY_W-1:0]  key_rd_s1;
	logic [STAT_W-1:0] st_rd_s1;
	logic [REC_W-1:0]  rec_rd_s1;
	logic [KEY_W-1:0]  want;
	logic              match;

	// captured entry
	logic              found_q;
	logic [IDX_W-1:0]  slot_q;
	logic [STAT_W-1:0] st_q;
	logic [REC_W-1:0]  rec_q;
	logic [IDX_W:0]    count_q;

	oht_rsp_t          res_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= req.opcode;
			key_q <= req.key;
			nst_q <= req.new_status;
			rin_q <= req.record_ref;
		end
	end

	// first hash cycle registers the quotient, the second forms the remainder
	assign h_prod   = (2*KEY_W+1)'(key_q) * (2*KEY_W+1)'(RECIP);
	assign h_back   = quot_q * KEY_W'(TABLE_SIZE);
	assign rem_next = IDX_W'(key_q - h_back);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstep_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.accept) hstep_q <= '0;
			else if (cmd.hash_en) hstep_q <= hstep_q + 1'b1;
			if (cmd.clear_en) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hash_en) quot_q <= KEY_W'(h_prod >> SHIFT);
	end

	// probe step grows by one each probe, sum stays below twice the size
	assign pos_sum  = {1'b0, pos_q} + k_q;
	assign pos_next = (pos_sum >= T_EXT) ? IDX_W'(pos_sum - T_EXT) : pos_sum[IDX_W-1:0];
	assign issue    = cmd.probe && (k_q != T_EXT);
	assign want     = (op_q == OP_INSERT) ? '0 : key_q;
	assign match    = valid_s1 && (key_rd_s1 == want);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.hash_en) k_q <= '0;
			else if (issue) k_q <= k_q + 1'b1;
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hash_en) pos_q <= rem_next;
		else if (issue) pos_q <= pos_next;
		if (issue) begin
			pos_s1    <= pos_q;
			last_s1   <= (k_q == T_LAST);
			key_rd_s1 <= key_mem[pos_q];
			st_rd_s1  <= st_mem[pos_q];
			rec_rd_s1 <= rec_mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (cmd.accept) found_q <= 1'b0;
			else if (cmd.probe && match) found_q <= 1'b1;
			if (cmd.upd_en) begin
				if (op_q == OP_INSERT) count_q <= count_q + 1'b1;
				else if (op_q == OP_REMOVE) count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe && match) begin
			slot_q <= pos_s1;
			st_q   <= (op_q == OP_INSERT || op_q == OP_SET_STATUS) ? nst_q : st_rd_s1;
			rec_q  <= (op_q == OP_INSERT) ? rin_q : rec_rd_s1;
		end
	end

	// table writes: clear sweep of the key memory after reset, then a key write on each insert or remove update
	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			key_mem[clr_q] <= '0;
		end else if (cmd.upd_en) begin
			if (op_q == OP_INSERT) key_mem[slot_q] <= key_q;
			else if (op_q == OP_REMOVE) key_mem[slot_q] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_en && (op_q == OP_INSERT || op_q == OP_SET_STATUS)) st_mem[slot_q] <= nst_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_en && op_q == OP_INSERT) rec_mem[slot_q] <= rin_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.ok         <= found_q;
			res_q.status_out <= found_q ? st_q : '0;
			res_q.record_out <= found_q ? rec_q : '0;
			res_q.occupancy  <= OCC_W'(count_q);
		end
	end

	assign rsp = res_q;

	assign stat.clear_last = cmd.clear_en && (clr_q == T_LAST[IDX_W-1:0]);
	assign stat.hash_last  = cmd.hash_en && (hstep_q == HSTEP_W'(HASH_STEPS - 1));
	assign stat.reject     = (key_q == '0) || (op_q == OP_INSERT && count_q == T_EXT);
	assign stat.hit        = match;
	assign stat.miss       = valid_s1 && !match && last_s1;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= T_EXT)
		else $error("entry count above table size");
	a_hit_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit |-> $past(issue))
		else $error("hit without an issued read");
	a_update_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_en |-> found_q)
		else $error("update without a found slot");
`endif
endmodule

[rtl/open_addressing_hash_table.sv]
// Keyed table of TABLE_SIZE slots with open addressing. Each request beat carries an
// operation (insert, remove, lookup, set status) and a key, zero being reserved; each one
// yields exactly one response beat with ok, the entry's status and record handle, and the
// occupancy after the operation. One request is worked at a time: after the accept cycle
// the home slot (key mod TABLE_SIZE) is found by a reciprocal multiply and then a
// back-multiply, then the walk makes one probe read per cycle from the slot memories,
// whose registered read port puts the compare in the cycle after the read. A hit ends
// the walk; a miss, or a lookup of an absent key, walks all TABLE_SIZE probes. Key zero
// and insert on a full table fail after the hash without probing. The request channel
// reopens in the cycle after the response is loaded, so the next request is taken while
// a response still waits; a second finished answer holds in the done state until the
// first one is taken. After reset the key memory is swept to empty, one slot per cycle,
// and the request channel opens once the sweep is done.
module open_addressing_hash_table #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  oht_pkg::oht_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output oht_pkg::oht_rsp_t rsp
);
	import oht_pkg::*;

	// controller to datapath commands and status back
	oht_cmd_t  cmd;
	oht_stat_t stat;

	oht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// slot memories, home slot unit, probe walk and response register
	oht_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
